### hw/rtl/ggbfs_pkg.sv
`default_nettype none
package ggbfs_pkg;

   localparam int GRID_SIDE_MAX = 64;
   localparam int SIDE_W = 6;
   localparam int CELL_W = 2 * SIDE_W;
   localparam int CELL_COUNT = GRID_SIDE_MAX * GRID_SIDE_MAX;
   localparam int DIM_W = 7;
   localparam int CNT_W = CELL_W + 1;
   localparam int KEY_W = 20;
   localparam int ENTRY_W = KEY_W + CELL_W;
   localparam int PAR_W = CELL_W + 1;
   localparam int CSR_IDX_W = 8;

   // key = max*10000 + min*4142, same as min*14142 + (max-min)*10000
   localparam logic [KEY_W-1:0] STEP_AXIS = KEY_W'(10000);
   localparam logic [KEY_W-1:0] STEP_DIAG_EXTRA = KEY_W'(4142);

   typedef enum logic [1:0] {
      KIND_WALL   = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_READ   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 8'd0,
      REG_GRID_HEIGHT = 8'd1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLR_ALL,
      ST_IDLE,
      ST_CLR_MARK,
      ST_ROOT,
      ST_POP_RD,
      ST_POP_CHK,
      ST_SDN_RD,
      ST_SDN_CMP,
      ST_NB_RD,
      ST_NB_CHK,
      ST_SUP_RD,
      ST_SUP_CMP,
      ST_PATH_UPD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CELL_W-1:0] addr;
      logic              wall_we;
      logic              wall_wd;
      logic              par_we;
      logic [PAR_W-1:0]  par_wd;
   } grid_req_type;

   typedef struct packed {
      logic [CELL_W-1:0]  rd0_addr;
      logic [CELL_W-1:0]  rd1_addr;
      logic               we;
      logic [CELL_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
   } heap_req_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(GRID_SIDE_MAX)) r = DIM_W'(GRID_SIDE_MAX);
      return r;
   endfunction

   // neighbour order: x offset outer, y offset inner; returns {ox, oy}
   function automatic logic [3:0] nb_offset(input logic [2:0] nb);
      logic [3:0] r;
      case (nb)
         3'd0: r = {2'b11, 2'b11};
         3'd1: r = {2'b11, 2'b00};
         3'd2: r = {2'b11, 2'b01};
         3'd3: r = {2'b00, 2'b11};
         3'd4: r = {2'b00, 2'b01};
         3'd5: r = {2'b01, 2'b11};
         3'd6: r = {2'b01, 2'b00};
         default: r = {2'b01, 2'b01};
      endcase
      return r;
   endfunction

   function automatic logic [SIDE_W-1:0] abs_diff(input logic [SIDE_W-1:0] a,
                                                  input logic [SIDE_W-1:0] b);
      logic [SIDE_W-1:0] r;
      r = (a > b) ? a - b : b - a;
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/ggbfs_grid.sv
`default_nettype none
module ggbfs_grid
   import ggbfs_pkg::*;
(
   input  wire logic         clock,
   input  wire grid_req_type req,
   output logic              wall_rd,
   output logic [PAR_W-1:0]  par_rd
);

   logic             wall_mem [CELL_COUNT];
   logic [PAR_W-1:0] par_mem  [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (req.wall_we) begin
         wall_mem[req.addr] <= req.wall_wd;
      end
      wall_rd <= wall_mem[req.addr];
   end

   // parent word: {marked, parent cell {y, x}}
   always_ff @(posedge clock) begin
      if (req.par_we) begin
         par_mem[req.addr] <= req.par_wd;
      end
      par_rd <= par_mem[req.addr];
   end

endmodule
`default_nettype wire

### hw/rtl/ggbfs_heap.sv
`default_nettype none
module ggbfs_heap
   import ggbfs_pkg::*;
(
   input  wire logic          clock,
   input  wire heap_req_type  req,
   output logic [ENTRY_W-1:0] rd0_data,
   output logic [ENTRY_W-1:0] rd1_data
);

   // entry: {key, y, x}; a plain unsigned compare gives key order, ties by cell index
   logic [ENTRY_W-1:0] heap_mem [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (req.we) begin
         heap_mem[req.wr_addr] <= req.wr_data;
      end
      rd0_data <= heap_mem[req.rd0_addr];
      rd1_data <= heap_mem[req.rd1_addr];
   end

endmodule
`default_nettype wire

### hw/rtl/grid_greedy_best_first_search.sv
// Greedy best-first search on an 8-connected grid of up to 64 x 64 cells.
// req channel: one transaction per item, tuser = kind (0 wall write,
// 1 search, 2 read next path cell, 3 nothing). rsp channel: exactly one
// transaction per item, in order. csr channel: grid_width (index 0) and
// grid_height (index 1), always ready, write only while idle.
// A search with all four coordinates inside the grid first clears the
// visited marks, then runs the frontier heap: a pop sifts down, and a
// neighbour is either skipped or pushed with a sift-up. Sift depth (log2
// of the heap fill) and the one write port of the heap memory set the
// search time. After reset the block sweeps the wall and parent memories
// with req_tready low; csr writes are taken meanwhile.
// A finished result sits in the rsp register; the block takes the next
// item while it waits, and stalls only if a second result is ready before
// the first has gone.
`default_nettype none
module grid_greedy_best_first_search
   import ggbfs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,  // cell_x, cell_y, blocked, end_x, end_y
   input  wire logic [1:0]           req_tuser,  // kind
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,  // visited_count, found, path_x, path_y
   output logic                      rsp_tuser,  // path_valid
   output logic                      rsp_tlast,  // path_last
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_data
);

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  sweep_ff, sweep_in;
   logic [DIM_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [SIDE_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [CELL_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CELL_W-1:0]  idx_ff, idx_in;
   logic [CELL_W-1:0]  lch_ff, lch_in;
   logic               rok_ff, rok_in;
   logic [ENTRY_W-1:0] elem_ff, elem_in;
   logic [CELL_W-1:0]  top_ff, top_in;
   logic [CELL_W-1:0]  ncell_ff, ncell_in;
   logic [2:0]         nb_ff, nb_in;
   logic               path_on_ff, path_on_in;
   logic [CELL_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]   res_visit_ff, res_visit_in;
   logic               res_found_ff, res_found_in;
   logic [CELL_W-1:0]  res_cell_ff, res_cell_in;
   logic               res_pv_ff, res_pv_in, res_pl_ff, res_pl_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in, rsp_last_ff, rsp_last_in;

   grid_req_type       grid_req;
   heap_req_type       heap_req;
   logic               wall_rd;
   logic [PAR_W-1:0]   par_rd;
   logic [ENTRY_W-1:0] rd0_data, rd1_data;

   ggbfs_grid u_grid (.clock(clock), .req(grid_req), .wall_rd(wall_rd), .par_rd(par_rd));
   ggbfs_heap u_heap (.clock(clock), .req(heap_req), .rd0_data(rd0_data),
                      .rd1_data(rd1_data));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   logic [SIDE_W-1:0]  q_cx, q_cy, q_ex, q_ey;
   logic               q_blk;
   logic [3:0]         offs;
   logic [DIM_W-1:0]   nx_ext, ny_ext;
   logic [SIDE_W-1:0]  ndx, ndy, dbig, dsmall;
   logic [KEY_W-1:0]   nkey;
   logic [CNT_W-1:0]   lch_wide;
   logic [CELL_W-1:0]  pidx;
   logic [ENTRY_W-1:0] cand;
   logic [CELL_W-1:0]  cand_idx;
   logic               nb_last;

   assign q_cx  = req_tdata[5:0];
   assign q_cy  = req_tdata[11:6];
   assign q_blk = req_tdata[12];
   assign q_ex  = req_tdata[18:13];
   assign q_ey  = req_tdata[24:19];

   always_comb begin
      offs   = nb_offset(nb_ff);
      nx_ext = DIM_W'(top_ff[SIDE_W-1:0]) + {{(DIM_W-2){offs[3]}}, offs[3:2]};
      ny_ext = DIM_W'(top_ff[CELL_W-1:SIDE_W]) + {{(DIM_W-2){offs[1]}}, offs[1:0]};
      ndx    = abs_diff(ncell_ff[SIDE_W-1:0], sx_ff);
      ndy    = abs_diff(ncell_ff[CELL_W-1:SIDE_W], sy_ff);
      dbig   = (ndx < ndy) ? ndy : ndx;
      dsmall = (ndx < ndy) ? ndx : ndy;
      nkey   = KEY_W'(dbig) * STEP_AXIS + KEY_W'(dsmall) * STEP_DIAG_EXTRA;
      lch_wide = {idx_ff, 1'b1};
      pidx     = CELL_W'((idx_ff - CELL_W'(1)) >> 1);
      cand     = rd0_data;
      cand_idx = lch_ff;
      if (rok_ff && (rd1_data < rd0_data)) begin
         cand     = rd1_data;
         cand_idx = lch_ff + CELL_W'(1);
      end
      nb_last = (nb_ff == 3'd7);
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      lch_in       = lch_ff;
      rok_in       = rok_ff;
      elem_in      = elem_ff;
      top_in       = top_ff;
      ncell_in     = ncell_ff;
      nb_in        = nb_ff;
      path_on_in   = path_on_ff;
      cursor_in    = cursor_ff;
      res_visit_in = res_visit_ff;
      res_found_in = res_found_ff;
      res_cell_in  = res_cell_ff;
      res_pv_in    = res_pv_ff;
      res_pl_in    = res_pl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      grid_req     = '0;
      heap_req     = '0;

      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  width_in  = clamp_dim(csr_data);
            REG_GRID_HEIGHT: height_in = clamp_dim(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLR_ALL: begin
            grid_req.addr    = sweep_ff;
            grid_req.wall_we = 1'b1;
            grid_req.par_we  = 1'b1;
            sweep_in         = sweep_ff + CELL_W'(1);
            if (sweep_ff == CELL_W'(CELL_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            grid_req.addr = cursor_ff;
            if (req_tvalid) begin
               res_visit_in = '0;
               res_found_in = 1'b0;
               res_cell_in  = '0;
               res_pv_in    = 1'b0;
               res_pl_in    = 1'b0;
               state_in     = ST_RESP;
               unique case (kind_type'(req_tuser))
                  KIND_WALL: begin
                     grid_req.addr    = {q_cy, q_cx};
                     grid_req.wall_we = 1'b1;
                     grid_req.wall_wd = q_blk;
                  end
                  KIND_SEARCH: begin
                     path_on_in = 1'b0;
                     sx_in      = q_cx;
                     sy_in      = q_cy;
                     root_in    = {q_ey, q_ex};
                     sweep_in   = '0;
                     if (DIM_W'(q_cx) < width_ff && DIM_W'(q_ex) < width_ff &&
                         DIM_W'(q_cy) < height_ff && DIM_W'(q_ey) < height_ff) begin
                        state_in = ST_CLR_MARK;
                     end
                  end
                  KIND_READ: begin
                     if (path_on_ff) begin
                        res_cell_in = cursor_ff;
                        res_pv_in   = 1'b1;
                        if (cursor_ff == root_ff) begin
                           res_pl_in  = 1'b1;
                           path_on_in = 1'b0;
                        end else begin
                           state_in = ST_PATH_UPD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PATH_UPD: begin
            cursor_in = par_rd[CELL_W-1:0];
            state_in  = ST_RESP;
         end
         ST_CLR_MARK: begin
            grid_req.addr   = sweep_ff;
            grid_req.par_we = 1'b1;
            sweep_in        = sweep_ff + CELL_W'(1);
            if (sweep_ff == CELL_W'(CELL_COUNT - 1)) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            grid_req.addr    = root_ff;
            grid_req.par_we  = 1'b1;
            grid_req.par_wd  = {1'b1, root_ff};
            heap_req.we      = 1'b1;
            heap_req.wr_addr = '0;
            heap_req.wr_data = {KEY_W'(0), root_ff};
            cnt_in           = CNT_W'(1);
            state_in         = ST_POP_RD;
         end
         ST_POP_RD: begin
            heap_req.rd0_addr = '0;
            heap_req.rd1_addr = CELL_W'(cnt_ff - CNT_W'(1));
            state_in = (cnt_ff == '0) ? ST_RESP : ST_POP_CHK;
         end
         ST_POP_CHK: begin
            top_in  = rd0_data[CELL_W-1:0];
            elem_in = rd1_data;
            cnt_in  = cnt_ff - CNT_W'(1);
            idx_in  = '0;
            if (rd0_data[CELL_W-1:0] == {sy_ff, sx_ff}) begin
               res_found_in = 1'b1;
               path_on_in   = 1'b1;
               cursor_in    = {sy_ff, sx_ff};
               state_in     = ST_RESP;
            end else begin
               state_in = ST_SDN_RD;
            end
         end
         ST_SDN_RD: begin
            if (lch_wide >= cnt_ff) begin
               heap_req.we      = 1'b1;
               heap_req.wr_addr = idx_ff;
               heap_req.wr_data = elem_ff;
               nb_in            = '0;
               state_in         = ST_NB_RD;
            end else begin
               heap_req.rd0_addr = lch_wide[CELL_W-1:0];
               heap_req.rd1_addr = lch_wide[CELL_W-1:0] + CELL_W'(1);
               lch_in            = lch_wide[CELL_W-1:0];
               rok_in            = (lch_wide + CNT_W'(1)) < cnt_ff;
               state_in          = ST_SDN_CMP;
            end
         end
         ST_SDN_CMP: begin
            heap_req.we      = 1'b1;
            heap_req.wr_addr = idx_ff;
            if (cand < elem_ff) begin
               heap_req.wr_data = cand;
               idx_in           = cand_idx;
               state_in         = ST_SDN_RD;
            end else begin
               heap_req.wr_data = elem_ff;
               nb_in            = '0;
               state_in         = ST_NB_RD;
            end
         end
         ST_NB_RD: begin
            grid_req.addr = {ny_ext[SIDE_W-1:0], nx_ext[SIDE_W-1:0]};
            ncell_in      = {ny_ext[SIDE_W-1:0], nx_ext[SIDE_W-1:0]};
            if (nx_ext < width_ff && ny_ext < height_ff) begin
               state_in = ST_NB_CHK;
            end else begin
               nb_in    = nb_ff + 3'd1;
               state_in = nb_last ? ST_POP_RD : ST_NB_RD;
            end
         end
         ST_NB_CHK: begin
            if (!wall_rd && !par_rd[PAR_W-1]) begin
               grid_req.addr   = ncell_ff;
               grid_req.par_we = 1'b1;
               grid_req.par_wd = {1'b1, top_ff};
               res_visit_in    = res_visit_ff + CNT_W'(1);
               elem_in         = {nkey, ncell_ff};
               idx_in          = cnt_ff[CELL_W-1:0];
               cnt_in          = cnt_ff + CNT_W'(1);
               state_in        = ST_SUP_RD;
            end else begin
               nb_in    = nb_ff + 3'd1;
               state_in = nb_last ? ST_POP_RD : ST_NB_RD;
            end
         end
         ST_SUP_RD: begin
            if (idx_ff == '0) begin
               heap_req.we      = 1'b1;
               heap_req.wr_addr = '0;
               heap_req.wr_data = elem_ff;
               nb_in            = nb_ff + 3'd1;
               state_in         = nb_last ? ST_POP_RD : ST_NB_RD;
            end else begin
               heap_req.rd0_addr = pidx;
               lch_in            = pidx;
               state_in          = ST_SUP_CMP;
            end
         end
         ST_SUP_CMP: begin
            heap_req.we      = 1'b1;
            heap_req.wr_addr = idx_ff;
            if (elem_ff < rd0_data) begin
               heap_req.wr_data = rd0_data;
               idx_in           = lch_ff;
               state_in         = ST_SUP_RD;
            end else begin
               heap_req.wr_data = elem_ff;
               nb_in            = nb_ff + 3'd1;
               state_in         = nb_last ? ST_POP_RD : ST_NB_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, res_cell_ff, res_found_ff, res_visit_ff};
               rsp_user_in  = res_pv_ff;
               rsp_last_in  = res_pl_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_ALL;
         sweep_ff     <= '0;
         width_ff     <= DIM_W'(GRID_SIDE_MAX);
         height_ff    <= DIM_W'(GRID_SIDE_MAX);
         cnt_ff       <= '0;
         path_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         cnt_ff       <= cnt_in;
         path_on_ff   <= path_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      root_ff      <= root_in;
      idx_ff       <= idx_in;
      lch_ff       <= lch_in;
      rok_ff       <= rok_in;
      elem_ff      <= elem_in;
      top_ff       <= top_in;
      ncell_ff     <= ncell_in;
      nb_ff        <= nb_in;
      cursor_ff    <= cursor_in;
      res_visit_ff <= res_visit_in;
      res_found_ff <= res_found_in;
      res_cell_ff  <= res_cell_in;
      res_pv_ff    <= res_pv_in;
      res_pl_ff    <= res_pl_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CELL_COUNT))
      else $error("heap fill beyond grid size");

   a_last_has_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_last_ff || rsp_user_ff))
      else $error("path end flagged without a path cell");

   a_found_opens_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_CHK && state_in == ST_RESP) |=> path_on_ff)
      else $error("reached start but path not armed");

   a_sweep_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR_ALL || state_ff == ST_CLR_MARK) |-> !req_tready)
      else $error("input taken during memory sweep");

endmodule
`default_nettype wire

### tb/grid_greedy_best_first_search_tb.sv
`default_nettype none
module grid_greedy_best_first_search_tb;
   import ggbfs_pkg::*;

   typedef struct {
      int unsigned visits;
      bit          found;
      int unsigned px;
      int unsigned py;
      bit          pvalid;
      bit          plast;
   } path_result_type;

   class path_scoreboard;
      bit              wall [CELL_COUNT];
      bit              seen [CELL_COUNT];
      int unsigned     parent [CELL_COUNT];
      int unsigned     hkey [CELL_COUNT];
      int unsigned     hcell [CELL_COUNT];
      int unsigned     hcount;
      int unsigned     cols, rows;
      int unsigned     cursor, root;
      bit              walking;
      path_result_type pending_q [$];
      int              errors;

      function new();
         cols = GRID_SIDE_MAX;
         rows = GRID_SIDE_MAX;
         walking = 0;
         hcount = 0;
         errors = 0;
         foreach (wall[i]) begin
            wall[i] = 0;
            parent[i] = 0;
         end
      endfunction

      function int unsigned clamp_side(int unsigned v);
         if (v == 0) return 1;
         if (v > GRID_SIDE_MAX) return GRID_SIDE_MAX;
         return v;
      endfunction

      function void write_reg(reg_index_type idx, logic [DIM_W-1:0] v);
         if (idx == REG_GRID_WIDTH) cols = clamp_side(v);
         else if (idx == REG_GRID_HEIGHT) rows = clamp_side(v);
      endfunction

      function bit ahead(int unsigned a, int unsigned b);
         if (hkey[a] != hkey[b]) return hkey[a] < hkey[b];
         return hcell[a] < hcell[b];
      endfunction

      function void swap_slot(int unsigned a, int unsigned b);
         int unsigned k, c;
         k = hkey[a]; c = hcell[a];
         hkey[a] = hkey[b]; hcell[a] = hcell[b];
         hkey[b] = k; hcell[b] = c;
      endfunction

      function void push(int unsigned k, int unsigned c);
         int unsigned i, p;
         i = hcount++;
         hkey[i] = k; hcell[i] = c;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!ahead(i, p)) break;
            swap_slot(i, p);
            i = p;
         end
      endfunction

      function int unsigned pop();
         int unsigned top, i, l, r, m;
         top = hcell[0];
         i = 0;
         hcount--;
         hkey[0] = hkey[hcount];
         hcell[0] = hcell[hcount];
         forever begin
            l = 2 * i + 1; r = l + 1; m = i;
            if (l < hcount && ahead(l, m)) m = l;
            if (r < hcount && ahead(r, m)) m = r;
            if (m == i) break;
            swap_slot(i, m);
            i = m;
         end
         return top;
      endfunction

      function int unsigned octile(int x, int y, int sx, int sy);
         int unsigned dx, dy, t;
         dx = (x > sx) ? x - sx : sx - x;
         dy = (y > sy) ? y - sy : sy - y;
         if (dx < dy) begin
            t = dx; dx = dy; dy = t;
         end
         return dy * 14142 + (dx - dy) * 10000;
      endfunction

      function void search(int sx, int sy, int ex, int ey, ref path_result_type r);
         int unsigned start, c, n;
         int cx, cy, nx, ny;
         walking = 0;
         hcount = 0;
         foreach (seen[i]) seen[i] = 0;
         if (sx >= cols || sy >= rows || ex >= cols || ey >= rows) return;
         start = sy * GRID_SIDE_MAX + sx;
         root = ey * GRID_SIDE_MAX + ex;
         seen[root] = 1;
         parent[root] = root;
         push(0, root);
         while (hcount > 0) begin
            c = pop();
            cx = c % GRID_SIDE_MAX;
            cy = c / GRID_SIDE_MAX;
            if (c == start) begin
               r.found = 1;
               walking = 1;
               cursor = start;
               break;
            end
            for (int di = -1; di <= 1; di++)
               for (int dj = -1; dj <= 1; dj++) begin
                  nx = cx + di; ny = cy + dj;
                  if (di == 0 && dj == 0) continue;
                  if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                  n = ny * GRID_SIDE_MAX + nx;
                  if (wall[n] || seen[n]) continue;
                  push(octile(nx, ny, sx, sy), n);
                  seen[n] = 1;
                  parent[n] = c;
                  r.visits++;
               end
         end
         r.visits &= 13'h1FFF;
      endfunction

      function void note_item(kind_type k, int cx, int cy, bit blk, int ex, int ey);
         path_result_type r;
         r = '{0, 0, 0, 0, 0, 0};
         case (k)
            KIND_WALL: wall[cy * GRID_SIDE_MAX + cx] = blk;
            KIND_SEARCH: search(cx, cy, ex, ey, r);
            KIND_READ: begin
               if (walking) begin
                  r.px = cursor % GRID_SIDE_MAX;
                  r.py = cursor / GRID_SIDE_MAX;
                  r.pvalid = 1;
                  if (cursor == root) begin
                     r.plast = 1;
                     walking = 0;
                  end else begin
                     cursor = parent[cursor];
                  end
               end
            end
            default: ;
         endcase
         pending_q.push_back(r);
      endfunction

      function void check_result(logic [31:0] d, logic pv, logic pl);
         path_result_type e;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %h", d);
            return;
         end
         e = pending_q.pop_front();
         if (d[12:0] != e.visits || d[13] != e.found || d[19:14] != e.px ||
             d[25:20] != e.py || d[31:26] != 0 || pv != e.pvalid || pl != e.plast) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp cnt=%0d fnd=%0d x=%0d y=%0d v=%0d l=%0d",
                         " got cnt=%0d fnd=%0d x=%0d y=%0d v=%0d l=%0d hi=%h"},
                        e.visits, e.found, e.px, e.py, e.pvalid, e.plast,
                        d[12:0], d[13], d[19:14], d[25:20], pv, pl, d[31:26]);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_data = '0;

   path_scoreboard sb = new();
   int send_idle = 28;
   int recv_idle = 46;
   int items_sent = 0;
   int cur_w = 64, cur_h = 64;

   grid_greedy_best_first_search dut (.*);

   initial forever #4 clock = ~clock;

   initial begin
      #(8 * 4_000_000);
      $display("** grid_greedy_best_first_search: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
      if (req_tvalid && req_tready)
         sb.note_item(kind_type'(req_tuser), req_tdata[5:0], req_tdata[11:6], req_tdata[12],
                      req_tdata[18:13], req_tdata[24:19]);
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   task automatic send(kind_type k, int cx, int cy, bit blk, int ex, int ey);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= k;
      req_tdata <= {7'd0, 6'(ey), 6'(ex), blk, 6'(cy), 6'(cx)};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [DIM_W-1:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_grid(int w, int h);
      write_csr(REG_GRID_WIDTH, DIM_W'(w));
      write_csr(REG_GRID_HEIGHT, DIM_W'(h));
      cur_w = sb.cols;
      cur_h = sb.rows;
   endtask

   function automatic int pick(int lim);
      // mostly inside the grid in use, now and then anywhere on the map
      if ($urandom_range(9) == 0) return $urandom_range(63);
      return $urandom_range(lim - 1);
   endfunction

   task automatic search_run();
      int walls;
      walls = $urandom_range(0, 4);
      repeat (walls)
         send(KIND_WALL, pick(cur_w), pick(cur_h), ($urandom_range(9) < 3), $urandom_range(63),
              $urandom_range(63));
      send(KIND_SEARCH, pick(cur_w), pick(cur_h), 0, pick(cur_w), pick(cur_h));
      repeat ($urandom_range(1, cur_w + cur_h + 2))
         send(KIND_READ, $urandom_range(63), $urandom_range(63), $urandom_range(1),
              $urandom_range(63), $urandom_range(63));
      if ($urandom_range(7) == 0)
         send(kind_type'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
              $urandom_range(1), $urandom_range(63), $urandom_range(63));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // full map: start equals end, then a long diagonal
      send(KIND_SEARCH, 0, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_SEARCH, 63, 63, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_READ, 63, 63, 1, 63, 63);
      send(KIND_NONE, 63, 63, 1, 63, 63);
      drain();
      // out of range register values, unknown index
      write_csr(reg_index_type'(8'd5), 7'd3);
      set_grid(0, 127);
      set_grid(65, 0);
      set_grid(4, 4);
      // wall at the end cell still expanded; wall at start never reached
      send(KIND_WALL, 3, 3, 1, 0, 0);
      send(KIND_SEARCH, 0, 0, 0, 3, 3);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_WALL, 0, 0, 1, 0, 0);
      send(KIND_SEARCH, 0, 0, 0, 3, 3);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_WALL, 0, 0, 0, 0, 0);
      send(KIND_WALL, 63, 63, 1, 0, 0);
      send(KIND_SEARCH, 4, 0, 0, 0, 0);
      send(KIND_SEARCH, 0, 0, 0, 0, 4);
      send(KIND_SEARCH, 1, 2, 0, 3, 0);
      drain();
      // path already found survives a register change
      set_grid(2, 2);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0, 0);
      drain();

      items_sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 28 : (phase == 1) ? 46 : 0;
         recv_idle = (phase == 0) ? 46 : (phase == 1) ? 28 : 0;
         case (phase)
            0: set_grid($urandom_range(1, 10), $urandom_range(1, 10));
            1: set_grid(64, $urandom_range(1, 3));
            default: set_grid($urandom_range(1, 3), 127);
         endcase
         while (items_sent < 24 * (phase + 1)) begin
            search_run();
            if (phase == 1 && $urandom_range(3) == 0) begin
               req_tvalid <= 0;
               @(posedge clock);
               while (sb.pending_q.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("** grid_greedy_best_first_search: PASSED **");
      else
         $display("** grid_greedy_best_first_search: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

### grid_greedy_best_first_search.f
hw/rtl/ggbfs_pkg.sv
hw/rtl/ggbfs_grid.sv
hw/rtl/ggbfs_heap.sv
hw/rtl/grid_greedy_best_first_search.sv
tb/grid_greedy_best_first_search_tb.sv
